### src/osrch_pkg.sv
`timescale 1ns / 1ps

package osrch_pkg;

  localparam int ROM_BITS_DEF = 64;
  localparam int ADDR_W = 64;

  // request kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_BIT   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_CLEARED = 3'd0;
  localparam logic [2:0] ST_STARTED = 3'd1;
  localparam logic [2:0] ST_BIT     = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_ABORTED = 3'd4;
  localparam logic [2:0] ST_FOUND   = 3'd5;
  localparam logic [2:0] ST_IGNORED = 3'd6;

  typedef struct packed {
    logic [1:0] kind;
    logic       presence;
    logic       bit_true;
    logic       bit_complement;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              direction;
    logic [ADDR_W-1:0] rom_address;
    logic              last_device;
  } out_item_t;

endpackage

### src/osrch_engine.sv
`timescale 1ns / 1ps

module osrch_engine #(
  parameter int ROM_BITS = osrch_pkg::ROM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  osrch_pkg::in_item_t  item,
  output osrch_pkg::out_item_t result
);

  localparam int PW = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
  localparam int JW = PW + 1;
  localparam logic [PW-1:0] LAST_POS = PW'(ROM_BITS - 1);

  logic [ROM_BITS-1:0] rom_r, rom_nxt;
  logic [JW-1:0]       junc_r, junc_nxt;
  logic [JW-1:0]       prev_r, prev_nxt;
  logic                abt_r, abt_nxt;
  logic                exh_r, exh_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic                act_r, act_nxt;

  logic junc_neg, at_junc, below_junc, dir;

  assign junc_neg   = junc_r[JW-1];
  assign at_junc    = !junc_neg && (junc_r[PW-1:0] == pos_r);
  assign below_junc = !junc_neg && (pos_r < junc_r[PW-1:0]);

  always_comb begin
    rom_nxt  = rom_r;
    junc_nxt = junc_r;
    prev_nxt = prev_r;
    abt_nxt  = abt_r;
    exh_nxt  = exh_r;
    pos_nxt  = pos_r;
    act_nxt  = act_r;
    dir      = 1'b0;
    result   = '0;
    result.status = osrch_pkg::ST_IGNORED;
    unique case (item.kind)
      osrch_pkg::KIND_CLEAR: begin
        rom_nxt  = '0;
        junc_nxt = '1;
        exh_nxt  = 1'b0;
        act_nxt  = 1'b0;
        pos_nxt  = '0;
        result.status = osrch_pkg::ST_CLEARED;
      end
      osrch_pkg::KIND_START: begin
        if (exh_r) begin
          result.status = osrch_pkg::ST_REFUSED;
        end else if (!item.presence) begin
          act_nxt = 1'b0;
          result.status = osrch_pkg::ST_ABORTED;
        end else begin
          act_nxt  = 1'b1;
          pos_nxt  = '0;
          prev_nxt = '1;
          abt_nxt  = 1'b1;
          result.status = osrch_pkg::ST_STARTED;
        end
      end
      osrch_pkg::KIND_BIT: begin
        if (act_r) begin
          if (item.bit_true && item.bit_complement) begin
            act_nxt = 1'b0;
            result.status = osrch_pkg::ST_ABORTED;
          end else begin
            if (!item.bit_true && !item.bit_complement) begin
              // discrepancy: follow the tree walk rules
              if (at_junc) begin
                dir      = 1'b1;
                junc_nxt = prev_r;
              end else if (below_junc) begin
                dir = rom_r[pos_r];
                if (!dir) abt_nxt = 1'b0;
              end else begin
                dir      = 1'b0;
                junc_nxt = {1'b0, pos_r};
                abt_nxt  = 1'b0;
              end
              if (!dir) prev_nxt = {1'b0, pos_r};
            end else begin
              dir = item.bit_true;
            end
            rom_nxt[pos_r] = dir;
            result.direction = dir;
            if (pos_r == LAST_POS) begin
              act_nxt = 1'b0;
              pos_nxt = '0;
              if (abt_nxt) exh_nxt = 1'b1;
              result.status      = osrch_pkg::ST_FOUND;
              result.rom_address = osrch_pkg::ADDR_W'(rom_nxt);
              result.last_device = abt_nxt;
            end else begin
              pos_nxt = pos_r + 1'b1;
              result.status = osrch_pkg::ST_BIT;
            end
          end
        end
      end
      default: begin
        result.status = osrch_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r  <= '0;
      junc_r <= '1;
      prev_r <= '1;
      abt_r  <= 1'b1;
      exh_r  <= 1'b0;
      pos_r  <= '0;
      act_r  <= 1'b0;
    end else if (step) begin
      rom_r  <= rom_nxt;
      junc_r <= junc_nxt;
      prev_r <= prev_nxt;
      abt_r  <= abt_nxt;
      exh_r  <= exh_nxt;
      pos_r  <= pos_nxt;
      act_r  <= act_nxt;
    end
  end

endmodule

### src/onewire_rom_search.sv
`timescale 1ns / 1ps
// 1-Wire search-ROM decision engine.
// Input channel (in_valid / in_stall / in_data): one request per item, either
// clear the search, start a pass (with the presence result of the bus reset),
// or one read bit pair. Output channel (out_valid / out_stall / out_data):
// exactly one result per request, in order: the status, the direction bit to
// write back, and on the last bit of a pass the ROM code and last-device flag.
// A request accepted into the request register passes the decision stage into
// the output register, whose valid flag drives out_valid. Throughput: one request
// per cycle while the receiver does not stall, set by the single decision stage
// between the request register and the result register.
// When the receiver stalls, the result holds in the output register and one
// more request may wait in the request register; in_stall rises only when both
// are full. Reset (rst_n low, synchronous) empties both registers and returns
// the search state to its initial value: no junction, empty ROM register,
// search not exhausted, no pass active.
module onewire_rom_search #(
  parameter int ROM_BITS = osrch_pkg::ROM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  osrch_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output osrch_pkg::out_item_t out_data
);

  logic                 req_vld_r;
  osrch_pkg::in_item_t  req_r;
  logic                 res_vld_r;
  osrch_pkg::out_item_t res_r;
  osrch_pkg::out_item_t res_nxt;
  logic                 advance;
  logic                 in_take;

  assign advance  = req_vld_r && (!res_vld_r || !out_stall);
  assign in_stall = req_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  osrch_engine #(
    .ROM_BITS(ROM_BITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (req_r),
    .result(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        req_vld_r <= 1'b1;
      end else if (advance) begin
        req_vld_r <= 1'b0;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (!out_stall) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

### src/osrch_checker.sv
`timescale 1ns / 1ps

module osrch_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input osrch_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input osrch_pkg::out_item_t out_data
);

  // a stalled request stays up and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // a held result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // address and last-device flag only on a found result
  a_addr_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != osrch_pkg::ST_FOUND)
      |-> (out_data.rom_address == '0) && !out_data.last_device)
    else $error("address shown on a result that is not found");

  // direction only for chosen bits and found
  a_dir_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.direction
      |-> (out_data.status == osrch_pkg::ST_BIT) ||
          (out_data.status == osrch_pkg::ST_FOUND))
    else $error("direction set on a result without a bit");

endmodule

bind onewire_rom_search osrch_checker u_osrch_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import osrch_pkg::*;

  localparam int N_BITS = ROM_BITS_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_pending = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;
  int sent_count = 0;

  // search state as the engine should hold it
  logic [63:0] rom_code;
  logic signed [6:0] junction;
  logic signed [6:0] last_zero;
  logic no_zero_branch;
  logic exhausted;
  logic [5:0] bit_pos;
  logic in_pass;

  out_item_t pending_results[$];
  out_item_t want_res;

  onewire_rom_search i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic in_item_t make_request(logic [1:0] kind, logic presence, logic bt,
                                            logic bc);
    in_item_t rq;
    rq.kind = kind;
    rq.presence = presence;
    rq.bit_true = bt;
    rq.bit_complement = bc;
    return rq;
  endfunction

  function automatic void clear_search_model();
    rom_code = '0;
    junction = '1;
    exhausted = 1'b0;
    in_pass = 1'b0;
    bit_pos = '0;
  endfunction

  function automatic out_item_t predict_search(in_item_t rq);
    out_item_t res;
    int pos;
    int junc;
    logic dir;
    res = '0;
    res.status = ST_IGNORED;
    pos = bit_pos;
    junc = junction;
    dir = 1'b0;
    case (rq.kind)
      KIND_CLEAR: begin
        clear_search_model();
        res.status = ST_CLEARED;
      end
      KIND_START: begin
        if (exhausted) begin
          res.status = ST_REFUSED;
        end else if (!rq.presence) begin
          in_pass = 1'b0;
          res.status = ST_ABORTED;
        end else begin
          in_pass = 1'b1;
          bit_pos = '0;
          last_zero = '1;
          no_zero_branch = 1'b1;
          res.status = ST_STARTED;
        end
      end
      KIND_BIT: begin
        if (in_pass && rq.bit_true && rq.bit_complement) begin
          in_pass = 1'b0;
          res.status = ST_ABORTED;
        end else if (in_pass) begin
          if (!rq.bit_true && !rq.bit_complement) begin
            // both values present on the bus: walk the tree
            if (pos == junc) begin
              dir = 1'b1;
              junction = last_zero;
            end else if (pos < junc) begin
              dir = rom_code[pos];
              if (!dir) no_zero_branch = 1'b0;
            end else begin
              dir = 1'b0;
              junction = 7'(pos);
              no_zero_branch = 1'b0;
            end
            if (!dir) last_zero = 7'(pos);
          end else begin
            dir = rq.bit_true;
          end
          rom_code[pos] = dir;
          res.direction = dir;
          if (pos + 1 >= N_BITS) begin
            in_pass = 1'b0;
            bit_pos = '0;
            if (no_zero_branch) exhausted = 1'b1;
            res.status = ST_FOUND;
            res.rom_address = rom_code;
            res.last_device = no_zero_branch;
          end else begin
            bit_pos = 6'(pos + 1);
            res.status = ST_BIT;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_request(input in_item_t rq, output out_item_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_search(rq);
    pending_results.push_back(res);
    sent_count++;
  endtask

  task automatic test_directed_cases();
    out_item_t res;
    idle_pct = 0;
    stall_pct = 0;
    send_request(make_request(KIND_BIT, 1'b0, 1'b0, 1'b0), res);
    send_request(make_request(KIND_UNUSED, 1'b1, 1'b1, 1'b1), res);
    send_request(make_request(KIND_START, 1'b0, 1'b0, 1'b0), res);
    send_request(make_request(KIND_BIT, 1'b1, 1'b1, 1'b0), res);
    send_request(make_request(KIND_START, 1'b1, 1'b0, 1'b0), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b1, 1'b0), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b0, 1'b1), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b0, 1'b0), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b0, 1'b0), res);
    // restart on top of a running pass
    send_request(make_request(KIND_START, 1'b1, 1'b1, 1'b1), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b1, 1'b0), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b0, 1'b1), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b0, 1'b0), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b0, 1'b0), res);
    // no device answers: abort, keep what was written
    send_request(make_request(KIND_BIT, 1'b0, 1'b1, 1'b1), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b0, 1'b0), res);
    send_request(make_request(KIND_START, 1'b0, 1'b1, 1'b0), res);
    send_request(make_request(KIND_CLEAR, 1'b1, 1'b1, 1'b1), res);
    send_request(make_request(KIND_START, 1'b1, 1'b0, 1'b1), res);
    send_request(make_request(KIND_BIT, 1'b1, 1'b0, 1'b0), res);
    send_request(make_request(KIND_CLEAR, 1'b0, 1'b0, 1'b0), res);
    send_request(make_request(KIND_BIT, 1'b0, 1'b1, 1'b0), res);
  endtask

  // Walk simulated buses of devices, each until its search is exhausted, until the
  // request budget is used, with occasional stray requests mixed into the passes.
  task automatic test_search_walk(input int send_idle, input int recv_stall, input int budget);
    logic [63:0] ids[$];
    bit alive[$];
    logic [63:0] base;
    logic [63:0] flip;
    int stop_at;
    int n_dev;
    int passes;
    int bit_idx;
    bit done;
    bit running;
    in_item_t rq;
    out_item_t res;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    stop_at = sent_count + budget;
    while (sent_count < stop_at) begin
      n_dev = $urandom_range(1, ($urandom_range(9) == 0) ? 8 : 3);
      base = {$urandom, $urandom};
      ids.delete();
      alive.delete();
      for (int d = 0; d < n_dev; d++) begin
        // keep ids close to each other so discrepancies fall deep in the tree
        flip = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        if ($urandom_range(3) == 0) flip = {$urandom, $urandom};
        ids.push_back(base ^ flip);
        alive.push_back(1'b1);
      end
      if ($urandom_range(7) == 0) ids[0] = '0;
      if ($urandom_range(7) == 0) ids[n_dev - 1] = '1;

      send_request(make_request(KIND_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom)), res);
      done = 1'b0;
      passes = 0;
      while (!done && passes < 3 * n_dev + 4) begin
        passes++;
        send_request(make_request(KIND_START, 1'b1, 1'($urandom), 1'($urandom)), res);
        running = (res.status == ST_STARTED);
        bit_idx = 0;
        foreach (alive[d]) alive[d] = 1'b1;
        while (running) begin
          if ($urandom_range(99) == 0) begin
            rq = make_request(2'($urandom_range(3)), 1'($urandom), 1'($urandom),
                              1'($urandom));
          end else begin
            // wired-AND of the id bit and its complement over devices still in
            rq = make_request(KIND_BIT, 1'($urandom), 1'b1, 1'b1);
            foreach (ids[d]) begin
              if (alive[d]) begin
                if (ids[d][bit_idx]) rq.bit_complement = 1'b0;
                else rq.bit_true = 1'b0;
              end
            end
          end
          send_request(rq, res);
          case (res.status)
            ST_STARTED: begin
              bit_idx = 0;
              foreach (alive[d]) alive[d] = 1'b1;
            end
            ST_BIT: begin
              foreach (ids[d]) if (ids[d][bit_idx] != res.direction) alive[d] = 1'b0;
              bit_idx++;
            end
            ST_FOUND: begin
              running = 1'b0;
              if (res.last_device) done = 1'b1;
            end
            ST_IGNORED: ;
            default: running = 1'b0;
          endcase
        end
      end
      if (done) begin
        send_request(make_request(KIND_START, 1'($urandom), 1'($urandom), 1'($urandom)), res);
        send_request(make_request(KIND_BIT, 1'($urandom), 1'b0, 1'b0), res);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_pending = 1'b1;
    test_search_walk(0, 0, 60);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d", out_data.status);
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        if (out_data.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_data.status);
          errors++;
        end
        if (out_data.direction !== want_res.direction) begin
          $error("direction: expected %0d, got %0d", want_res.direction, out_data.direction);
          errors++;
        end
        if (out_data.rom_address !== want_res.rom_address) begin
          $error("rom_address: expected %h, got %h", want_res.rom_address,
                 out_data.rom_address);
          errors++;
        end
        if (out_data.last_device !== want_res.last_device) begin
          $error("last_device: expected %0d, got %0d", want_res.last_device,
                 out_data.last_device);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("onewire_rom_search regression: fail");
      $finish;
    end
  end

  initial begin
    clear_search_model();
    last_zero = '1;
    no_zero_branch = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_search_walk(0, 0, 270);
    test_search_walk(75, 0, 270);
    test_backpressure();
    test_search_walk(0, 75, 270);
    test_search_walk(26, 26, 270);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("onewire_rom_search regression: pass");
    end else begin
      $display("onewire_rom_search regression: fail");
    end
    $finish;
  end

endmodule

### files.f
src/osrch_pkg.sv
src/osrch_engine.sv
src/onewire_rom_search.sv
src/osrch_checker.sv
bench/tb_top.sv
